// ===== rtl/lse_pkg.sv =====
`timescale 1ns / 1ps

package lse_pkg;

    localparam int DEPTH    = 128;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int WORD_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH   = 3'd0,
        FN_POP    = 3'd1,
        FN_TOP    = 3'd2,
        FN_SWAP   = 3'd3,
        FN_REV    = 3'd4,
        FN_CLEAR  = 3'd5,
        FN_SEARCH = 3'd6,
        FN_NOP    = 3'd7
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

endpackage

// ===== rtl/lse_in_if.sv =====
`timescale 1ns / 1ps

interface lse_in_if;

    logic                              valid;
    logic                              ready;
    logic [lse_pkg::FUNC_W-1:0]        func;
    logic signed [lse_pkg::WORD_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink (input valid, input func, input value, output ready);

endinterface

// ===== rtl/lse_out_if.sv =====
`timescale 1ns / 1ps

interface lse_out_if;

    logic                              valid;
    logic                              ready;
    logic [lse_pkg::STATUS_W-1:0]      status;
    logic signed [lse_pkg::WORD_W-1:0] data;
    logic                              found;
    logic [lse_pkg::COUNT_W-1:0]       count;

    modport source (output valid, output status, output data, output found, output count,
                    input ready);
    modport sink (input valid, input status, input data, input found, input count,
                  output ready);

endinterface

// ===== rtl/lse_ram.sv =====
`timescale 1ns / 1ps

module lse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/lse_ctrl.sv =====
`timescale 1ns / 1ps

module lse_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    lse_in_if.sink                    req,
    lse_out_if.source                 rsp,
    output lse_pkg::ram_req_t         ram_req,
    input  logic [lse_pkg::WORD_W-1:0] rd_data
);

    import lse_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_TOP_CAP,
        S_SW_RDLO,
        S_SW_RDHI,
        S_SW_WRLO,
        S_SW_WRHI,
        S_SEARCH,
        S_OUTPUT
    } state_t;

    state_t            state_reg, state_next;
    func_t             func_reg, func_next;
    logic [WORD_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [ADDR_W-1:0] lo_reg, lo_next;
    logic [ADDR_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [WORD_W-1:0] tmp_reg, tmp_next;
    status_t           st_reg, st_next;
    logic [WORD_W-1:0] dat_reg, dat_next;
    logic              fnd_reg, fnd_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [WORD_W-1:0] out_data_reg, out_data_next;
    logic              out_found_reg, out_found_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    logic [CNT_W-1:0]  fill_m1;
    logic [ADDR_W-1:0] top_idx;
    logic              match;

    assign fill_m1 = fill_reg - CNT_W'(1);
    assign top_idx = fill_m1[ADDR_W-1:0];
    assign match   = pend_reg && (rd_data == value_reg);

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.data   = out_data_reg;
    assign rsp.found  = out_found_reg;
    assign rsp.count  = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        value_next      = value_reg;
        fill_next       = fill_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        tmp_next        = tmp_reg;
        st_next         = st_reg;
        dat_next        = dat_reg;
        fnd_next        = fnd_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;
        ram_req         = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = func_t'(req.func);
                    value_next = req.value;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                st_next    = ST_OK;
                dat_next   = '0;
                fnd_next   = 1'b0;
                state_next = S_OUTPUT;
                unique case (func_reg) inside
                    FN_PUSH:
                    begin
                        if (fill_reg == CNT_W'(DEPTH))
                        begin
                            st_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            ram_req.wr_en   = 1'b1;
                            ram_req.wr_addr = fill_reg[ADDR_W-1:0];
                            ram_req.wr_data = value_reg;
                            fill_next       = fill_reg + CNT_W'(1);
                        end
                    end
                    FN_POP, FN_TOP:
                    begin
                        if (fill_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else
                        begin
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = top_idx;
                            state_next      = S_TOP_CAP;
                        end
                    end
                    FN_SWAP, FN_REV:
                    begin
                        if (fill_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else if (top_idx != '0)
                        begin
                            lo_next    = '0;
                            hi_next    = top_idx;
                            state_next = S_SW_RDLO;
                        end
                    end
                    FN_CLEAR:
                    begin
                        fill_next = '0;
                    end
                    FN_SEARCH:
                    begin
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        state_next = S_SEARCH;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_TOP_CAP:
            begin
                dat_next = rd_data;
                if (func_reg == FN_POP)
                begin
                    fill_next = fill_m1;
                end
                state_next = S_OUTPUT;
            end
            S_SW_RDLO:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = lo_reg;
                state_next      = S_SW_RDHI;
            end
            S_SW_RDHI:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = hi_reg;
                tmp_next        = rd_data;
                state_next      = S_SW_WRLO;
            end
            S_SW_WRLO:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = lo_reg;
                ram_req.wr_data = rd_data;
                state_next      = S_SW_WRHI;
            end
            S_SW_WRHI:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = hi_reg;
                ram_req.wr_data = tmp_reg;
                if ((func_reg == FN_REV) && ((lo_reg + ADDR_W'(1)) < (hi_reg - ADDR_W'(1))))
                begin
                    lo_next    = lo_reg + ADDR_W'(1);
                    hi_next    = hi_reg - ADDR_W'(1);
                    state_next = S_SW_RDLO;
                end
                else
                begin
                    state_next = S_OUTPUT;
                end
            end
            S_SEARCH:
            begin
                if (match)
                begin
                    fnd_next   = 1'b1;
                    pend_next  = 1'b0;
                    state_next = S_OUTPUT;
                end
                else if (idx_reg < fill_reg)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = idx_reg[ADDR_W-1:0];
                    idx_next        = idx_reg + CNT_W'(1);
                    pend_next       = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_OUTPUT;
                end
            end
            S_OUTPUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_data_next   = dat_reg;
                    out_found_next  = fnd_reg;
                    out_count_next  = COUNT_W'(fill_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            func_reg       <= FN_NOP;
            value_reg      <= '0;
            fill_reg       <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            tmp_reg        <= '0;
            st_reg         <= ST_OK;
            dat_reg        <= '0;
            fnd_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_data_reg   <= '0;
            out_found_reg  <= 1'b0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            func_reg       <= func_next;
            value_reg      <= value_next;
            fill_reg       <= fill_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            tmp_reg        <= tmp_next;
            st_reg         <= st_next;
            dat_reg        <= dat_next;
            fnd_reg        <= fnd_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_data_reg   <= out_data_next;
            out_found_reg  <= out_found_next;
            out_count_reg  <= out_count_next;
        end
    end

endmodule

// ===== rtl/lifo_stack_engine.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Fields                        Meaning
// req      in   func, value                   one operation word per handshake
// rsp      out  status, data, found, count    one result word per operation
//
// Push, clear and no-op finish in the execute state; pop and peek also capture the word read.
// Swap exchanges bottom and top words; reverse does so pair by pair from the ends inward;
// search reads the entries in turn. All stack words sit in one RAM with a single read port.
// Reset empties the stack; no clearing pass is needed.
// A finished result waits in the output register while the next word is accepted;
// if it is still held when the next result is ready, the block stalls until it is taken.

module lifo_stack_engine (
    input logic       clk,
    input logic       rst_n,
    lse_in_if.sink    req,
    lse_out_if.source rsp
);

    import lse_pkg::*;

    ram_req_t          ram_req;
    logic [WORD_W-1:0] rd_data;

    lse_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .ram_req (ram_req),
        .rd_data (rd_data)
    );

    lse_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (rd_data)
    );

    a_no_rd_wr_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.wr_en && ram_req.rd_en))
        else $error("RAM read and write issued in the same cycle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("Input accepted again while an operation is in progress");

    a_found_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.found) |-> (rsp.status == ST_OK))
        else $error("Search hit reported with a non-ok status");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_OVERFLOW)) |-> (rsp.count == COUNT_W'(DEPTH)))
        else $error("Overflow reported while the stack is not full");

endmodule

// ===== tb/lse_stack_checker.sv =====
`timescale 1ns / 1ps

module lse_stack_checker
    import lse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    lse_in_if    req,
    lse_out_if   rsp,
    output int   fail_count,
    output int   pending,
    output int   words_checked,
    output int   overflows,
    output int   hits,
    output int   deepest
);

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] data;
        logic                     found;
        logic [COUNT_W-1:0]       count;
    } stack_result_t;

    logic signed [WORD_W-1:0] stack_mem [DEPTH];
    int unsigned              depth_now;
    stack_result_t            awaited_q [$];

    // Applies one operation to the shadow stack and returns the result word it must produce.
    function automatic stack_result_t apply_op(input func_t op,
                                               input logic signed [WORD_W-1:0] word);
        stack_result_t            r;
        logic signed [WORD_W-1:0] tmp;
        int unsigned              i;
        r.status = ST_OK;
        r.data   = '0;
        r.found  = 1'b0;
        case (op)
            FN_PUSH:
            begin
                if (depth_now >= DEPTH)
                begin
                    r.status = ST_OVERFLOW;
                end
                else
                begin
                    stack_mem[depth_now] = word;
                    depth_now++;
                end
            end
            FN_POP:
            begin
                if (depth_now == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    depth_now--;
                    r.data = stack_mem[depth_now];
                end
            end
            FN_TOP:
            begin
                if (depth_now == 0)
                    r.status = ST_EMPTY;
                else
                    r.data = stack_mem[depth_now - 1];
            end
            FN_SWAP:
            begin
                if (depth_now == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    tmp                      = stack_mem[0];
                    stack_mem[0]             = stack_mem[depth_now - 1];
                    stack_mem[depth_now - 1] = tmp;
                end
            end
            FN_REV:
            begin
                if (depth_now == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    for (i = 0; i < depth_now / 2; i++)
                    begin
                        tmp                          = stack_mem[i];
                        stack_mem[i]                 = stack_mem[depth_now - 1 - i];
                        stack_mem[depth_now - 1 - i] = tmp;
                    end
                end
            end
            FN_CLEAR:
            begin
                depth_now = 0;
            end
            FN_SEARCH:
            begin
                for (i = 0; i < depth_now; i++)
                begin
                    if (stack_mem[i] == word)
                        r.found = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.count = COUNT_W'(depth_now);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stack_result_t want;
        if (!rst_n)
        begin
            awaited_q.delete();
            depth_now     = 0;
            fail_count    = 0;
            words_checked = 0;
            overflows     = 0;
            hits          = 0;
            deepest       = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                words_checked++;
                if (awaited_q.size() == 0)
                begin
                    $error("result word arrived with no operation outstanding");
                    fail_count++;
                end
                else
                begin
                    want = awaited_q.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d", want.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.data !== want.data)
                    begin
                        $error("data mismatch: expected %0d, got %0d", want.data, rsp.data);
                        fail_count++;
                    end
                    if (rsp.found !== want.found)
                    begin
                        $error("found mismatch: expected %0d, got %0d", want.found, rsp.found);
                        fail_count++;
                    end
                    if (rsp.count !== want.count)
                    begin
                        $error("count mismatch: expected %0d, got %0d", want.count, rsp.count);
                        fail_count++;
                    end
                    if (want.status == ST_OVERFLOW)
                        overflows++;
                    if (want.found)
                        hits++;
                end
            end
            if (req.valid && req.ready)
            begin
                awaited_q.push_back(apply_op(func_t'(req.func), req.value));
                if (depth_now > deepest)
                    deepest = depth_now;
            end
        end
        pending = awaited_q.size();
    end

endmodule

// ===== tb/lifo_stack_engine_tb.sv =====
`timescale 1ns / 1ps

module lifo_stack_engine_tb;

    import lse_pkg::*;

    localparam int N_ITEMS     = 1550;
    localparam int TAIL_CYCLES = 300;

    logic clk;
    logic rst_n;

    int  fail_count;
    int  pending_words;
    int  words_checked;
    int  overflows;
    int  hits;
    int  deepest;
    int  sent;
    int  recent_wr;
    bit  tx_calm;
    bit  rx_calm;
    logic signed [WORD_W-1:0] recent_words [16] = '{default: '0};

    lse_in_if  req ();
    lse_out_if rsp ();

    lifo_stack_engine uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    lse_stack_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending       (pending_words),
        .words_checked (words_checked),
        .overflows     (overflows),
        .hits          (hits),
        .deepest       (deepest)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9)) inside
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 100;
            3:       return -1;
            4:       return 0;
            [5:6]:   return WORD_W'($urandom_range(0, 8)) - 4;
            7:       return recent_words[$urandom_range(0, 15)];
            default: return $urandom();
        endcase
    endfunction

    task automatic send_word(input func_t op, input logic signed [WORD_W-1:0] word);
        int gap;
        if ($urandom_range(0, 99) < 2)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.func  <= op;
        req.value <= word;
        if (op == FN_PUSH)
        begin
            recent_words[recent_wr] = word;
            recent_wr = (recent_wr + 1) % 16;
        end
        sent++;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_words != 0);
        @(posedge clk);
    endtask

    task automatic random_op(input int push_pct);
        int    roll;
        func_t op;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
        begin
            op = FN_PUSH;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                op = FN_POP;
            else if (roll < 55)
                op = FN_TOP;
            else if (roll < 65)
                op = FN_SWAP;
            else if (roll < 73)
                op = FN_REV;
            else if (roll < 75)
                op = FN_CLEAR;
            else if (roll < 93)
                op = FN_SEARCH;
            else
                op = FN_NOP;
        end
        if (op == FN_SEARCH && $urandom_range(0, 1) == 1)
            send_word(op, recent_words[$urandom_range(0, 15)]);
        else
            send_word(op, pick_word());
    endtask

    task automatic fill_to_brim();
        repeat (DEPTH + 2) send_word(FN_PUSH, pick_word());
        send_word(FN_REV, pick_word());
        send_word(FN_SEARCH, recent_words[$urandom_range(0, 15)]);
        send_word(FN_SWAP, pick_word());
        send_word(FN_TOP, pick_word());
        send_word(FN_SEARCH, $urandom());
        send_word(FN_PUSH, pick_word());
    endtask

    initial
    begin
        int push_pct;
        int block_len;
        bit refilled;
        rst_n     = 1'b0;
        req.valid <= 1'b0;
        req.func  <= FN_NOP;
        req.value <= '0;
        sent      = 0;
        recent_wr = 0;
        refilled  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        send_word(FN_POP, 0);
        send_word(FN_TOP, 0);
        send_word(FN_SWAP, 0);
        send_word(FN_REV, 0);
        send_word(FN_SEARCH, 0);
        send_word(FN_CLEAR, 0);
        send_word(FN_NOP, -1);
        send_word(FN_PUSH, -1);
        send_word(FN_SWAP, 0);
        send_word(FN_REV, 0);
        send_word(FN_PUSH, 32'sh7FFF_FFFF);
        send_word(FN_PUSH, 32'sh8000_0000);
        send_word(FN_PUSH, 100);
        send_word(FN_PUSH, 0);
        send_word(FN_TOP, 0);
        send_word(FN_SEARCH, 32'sh8000_0000);
        send_word(FN_SEARCH, 5);
        send_word(FN_SWAP, 0);
        send_word(FN_REV, 0);
        send_word(FN_POP, 0);
        send_word(FN_SEARCH, -1);
        send_word(FN_CLEAR, 0);
        send_word(FN_POP, 0);
        send_word(FN_PUSH, 1);
        send_word(FN_CLEAR, 0);
        wait_drained();

        fill_to_brim();
        wait_drained();

        while (sent < N_ITEMS)
        begin
            block_len = $urandom_range(20, 200);
            case ($urandom_range(0, 2))
                0:       push_pct = 80;
                1:       push_pct = 50;
                default: push_pct = 25;
            endcase
            repeat (block_len)
            begin
                if (sent < N_ITEMS)
                    random_op(push_pct);
            end
            if (!refilled && sent > N_ITEMS / 2)
            begin
                refilled = 1'b1;
                fill_to_brim();
            end
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d stack operations over all eight selectors; %0d result words checked.",
                 sent, words_checked);
        $display("Overflowing pushes: %0d, search hits: %0d, deepest fill: %0d of %0d entries.",
                 overflows, hits, deepest, DEPTH);
        if (fail_count == 0 && pending_words == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int n;
        rsp.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 99) < 2)
                rx_calm = !rx_calm;
            n = rx_calm ? 0 : $urandom_range(0, 10);
            if (n > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        #30_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
